// ===== rtl/tdl_pkg.sv =====
// Shared types, constants and functions of the table-driven lexer scanner.
`default_nettype none

package tdl_pkg;

	// Table geometry
	localparam int STATE_COUNT = 32;
	localparam int CLASS_COUNT = 17;
	localparam int TBL_DEPTH   = STATE_COUNT * CLASS_COUNT;
	localparam int TBL_ADDR_W  = $clog2(TBL_DEPTH);

	// Field widths fixed by the item format
	localparam int STATE_W = 5;
	localparam int CLASS_W = 5;
	localparam int CODE_W  = 5;
	localparam int CHAR_W  = 8;
	localparam int ENTRY_W = STATE_W + CODE_W;

	// Request queue between front and back, power of two deep
	localparam int QUEUE_DEPTH = 2;

	// Configuration port
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_ADDR_W-3:0] REG_CONSUME_CODE = '0;
	localparam logic [CODE_W-1:0] CONSUME_RESET = CODE_W'(18);

	// Commands
	localparam logic CMD_SCAN  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Character classes
	localparam logic [CLASS_W-1:0] CLS_LETTER  = CLASS_W'(0);
	localparam logic [CLASS_W-1:0] CLS_UNDER   = CLASS_W'(1);
	localparam logic [CLASS_W-1:0] CLS_MINUS   = CLASS_W'(2);
	localparam logic [CLASS_W-1:0] CLS_PLUS    = CLASS_W'(3);
	localparam logic [CLASS_W-1:0] CLS_DOT     = CLASS_W'(4);
	localparam logic [CLASS_W-1:0] CLS_UPPER_E = CLASS_W'(5);
	localparam logic [CLASS_W-1:0] CLS_LOWER_E = CLASS_W'(6);
	localparam logic [CLASS_W-1:0] CLS_DIGIT   = CLASS_W'(7);
	localparam logic [CLASS_W-1:0] CLS_GT      = CLASS_W'(8);
	localparam logic [CLASS_W-1:0] CLS_EQ      = CLASS_W'(9);
	localparam logic [CLASS_W-1:0] CLS_BANG    = CLASS_W'(10);
	localparam logic [CLASS_W-1:0] CLS_SPACE   = CLASS_W'(11);
	localparam logic [CLASS_W-1:0] CLS_OTHER   = CLASS_W'(12);
	localparam logic [CLASS_W-1:0] CLS_LT      = CLASS_W'(13);
	localparam logic [CLASS_W-1:0] CLS_SLASH   = CLASS_W'(14);
	localparam logic [CLASS_W-1:0] CLS_STAR    = CLASS_W'(15);
	localparam logic [CLASS_W-1:0] CLS_NEWLINE = CLASS_W'(16);

	// Input request as it arrives
	typedef struct packed {
		logic               command;
		logic [CHAR_W-1:0]  char_byte;
		logic [STATE_W-1:0] entry_state;
		logic [CLASS_W-1:0] entry_class;
		logic [STATE_W-1:0] entry_next;
		logic [CODE_W-1:0]  entry_code;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [CODE_W-1:0] token_code;
		logic              rescanned;
		logic              stuck;
		logic              last;
	} out_item_t;

	// Classified request held in the queue
	typedef struct packed {
		logic               command;
		logic [CLASS_W-1:0] cls;
		logic [STATE_W-1:0] entry_state;
		logic [CLASS_W-1:0] entry_class;
		logic [STATE_W-1:0] entry_next;
		logic [CODE_W-1:0]  entry_code;
	} q_item_t;

	// Fixed byte-to-class map
	function automatic logic [CLASS_W-1:0] char_class(input logic [CHAR_W-1:0] b);
		logic [CLASS_W-1:0] c;
		case (b) inside
			8'h45:                   c = CLS_UPPER_E;
			8'h65:                   c = CLS_LOWER_E;
			[8'h41:8'h5A], [8'h61:8'h7A]: c = CLS_LETTER;
			[8'h30:8'h39]:           c = CLS_DIGIT;
			8'h5F:                   c = CLS_UNDER;
			8'h2D:                   c = CLS_MINUS;
			8'h2B:                   c = CLS_PLUS;
			8'h2E:                   c = CLS_DOT;
			8'h3E:                   c = CLS_GT;
			8'h3D:                   c = CLS_EQ;
			8'h21:                   c = CLS_BANG;
			8'h20, 8'h0D:            c = CLS_SPACE;
			8'h3C:                   c = CLS_LT;
			8'h2F:                   c = CLS_SLASH;
			8'h2A:                   c = CLS_STAR;
			8'h0A:                   c = CLS_NEWLINE;
			default:                 c = CLS_OTHER;
		endcase
		return c;
	endfunction

	// Row-major table address: state * CLASS_COUNT + class
	function automatic logic [TBL_ADDR_W-1:0] tbl_addr(input logic [STATE_W-1:0] st,
			input logic [CLASS_W-1:0] cl);
		return TBL_ADDR_W'(st) * TBL_ADDR_W'(CLASS_COUNT) + TBL_ADDR_W'(cl);
	endfunction

	// Stored next states past the last row fall back to the start state
	function automatic logic [STATE_W-1:0] fix_state(input logic [STATE_W-1:0] st);
		return (int'(st) >= STATE_COUNT) ? '0 : st;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tdl_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module tdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; rdata holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tdl_front.sv =====
// Front end: accepts requests and maps the character byte to its class.
`default_nettype none

module tdl_front (
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tdl_pkg::in_item_t in_data,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output tdl_pkg::q_item_t       push_item
);

	import tdl_pkg::*;

	// Pass handshake to the queue
	assign push_valid = in_valid;
	assign in_ready   = push_ready;

	// Classify and repack
	always_comb begin
		push_item.command     = in_data.command;
		push_item.cls         = char_class(in_data.char_byte);
		push_item.entry_state = in_data.entry_state;
		push_item.entry_class = in_data.entry_class;
		push_item.entry_next  = in_data.entry_next;
		push_item.entry_code  = in_data.entry_code;
	end

endmodule

`default_nettype wire

// ===== rtl/tdl_queue.sv =====
// Short FIFO of classified requests between front and back.
`default_nettype none

module tdl_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire tdl_pkg::q_item_t push_item,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output tdl_pkg::q_item_t      pop_item
);

	import tdl_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_item_t          slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tdl_back.sv =====
// Back end: table memory, scan state sequencer and result register.
`default_nettype none

module tdl_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	output logic                             q_ready,
	input  wire tdl_pkg::q_item_t            q_item,
	input  wire logic [tdl_pkg::CODE_W-1:0]  consume_code,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output tdl_pkg::out_item_t               out_data
);

	import tdl_pkg::*;

	// Sequencer states
	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_LOOK1 = 2'd1;
	localparam logic [1:0] B_LOOK2 = 2'd2;
	localparam logic [1:0] B_EMIT2 = 2'd3;

	logic [1:0]            st_q, st_d;
	logic [STATE_W-1:0]    scan_q, scan_d;
	logic [CLASS_W-1:0]    cls_q, cls_d;
	logic [CODE_W-1:0]     code_q, code_d;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic                  ram_we, ram_re;
	logic [TBL_ADDR_W-1:0] ram_addr;
	logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
	logic [CODE_W-1:0]     rd_code;
	logic [STATE_W-1:0]    rd_next;
	logic                  out_free;
	logic                  emit;
	out_item_t             emit_item;
	logic                  write_ok;

	// Next-state and token-code tables share one entry
	tdl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TBL_DEPTH)
	) u_tbl (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd_next   = ram_rdata[ENTRY_W-1:CODE_W];
	assign rd_code   = ram_rdata[CODE_W-1:0];
	assign ram_wdata = {q_item.entry_next, q_item.entry_code};
	assign write_ok  = (int'(q_item.entry_state) < STATE_COUNT) &&
		(int'(q_item.entry_class) < CLASS_COUNT);
	assign out_free  = !out_valid_q || out_ready;

	// Sequencer
	always_comb begin
		st_d      = st_q;
		scan_d    = scan_q;
		cls_d     = cls_q;
		code_d    = code_q;
		q_ready   = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = tbl_addr(scan_q, q_item.cls);
		emit      = 1'b0;
		emit_item = '0;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					q_ready = 1'b1;
					if (q_item.command == CMD_WRITE) begin
						ram_addr = tbl_addr(q_item.entry_state, q_item.entry_class);
						ram_we   = write_ok;
					end else begin
						ram_re = 1'b1;
						cls_d  = q_item.cls;
						st_d   = B_LOOK1;
					end
				end
			end
			B_LOOK1: begin
				if (rd_code == '0) begin
					scan_d = fix_state(rd_next);
					st_d   = B_IDLE;
				end else if (rd_code == consume_code) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_item = '{token_code: rd_code, rescanned: 1'b0,
							stuck: 1'b0, last: 1'b1};
						scan_d    = '0;
						st_d      = B_IDLE;
					end
				end else if (scan_q == '0) begin
					// start state rejects: drop the character
					if (out_free) begin
						emit      = 1'b1;
						emit_item = '{token_code: rd_code, rescanned: 1'b0,
							stuck: 1'b1, last: 1'b1};
						st_d      = B_IDLE;
					end
				end else begin
					// retract: look the character up again from the start state
					ram_re   = 1'b1;
					ram_addr = tbl_addr('0, cls_q);
					code_d   = rd_code;
					st_d     = B_LOOK2;
				end
			end
			B_LOOK2: begin
				if (out_free) begin
					emit = 1'b1;
					if (rd_code == '0) begin
						emit_item = '{token_code: code_q, rescanned: 1'b1,
							stuck: 1'b0, last: 1'b1};
						scan_d    = fix_state(rd_next);
						st_d      = B_IDLE;
					end else begin
						emit_item = '{token_code: code_q, rescanned: 1'b1,
							stuck: 1'b0, last: 1'b0};
						scan_d    = '0;
						code_d    = rd_code;
						st_d      = B_EMIT2;
					end
				end
			end
			B_EMIT2: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_item = '{token_code: code_q, rescanned: 1'b0,
						stuck: (code_q != consume_code), last: 1'b1};
					st_d      = B_IDLE;
				end
			end
			default: begin
				st_d = B_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			scan_q <= scan_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cls_q  <= cls_d;
		code_q <= code_d;
		if (emit) begin
			out_data_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/table_driven_lexer_dfa.sv =====
// Top level: table-driven lexer scanner with APB register port.
// A scanned character is looked up in B_LOOK1; code zero only moves the scan state on,
// other codes give a result, and a retract looks it up again in B_LOOK2 from the start state.
// A retract may add a second result from B_EMIT2; new requests are taken only in B_IDLE.
// Reset: arst_n clears the queue, scan state and result valid flag; consume_code becomes 18.
// The tables are not cleared and must be written before scanning.
`default_nettype none

module table_driven_lexer_dfa (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire tdl_pkg::in_item_t                   in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output tdl_pkg::out_item_t                       out_data,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [tdl_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire logic [tdl_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic      [tdl_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                     pready
);

	import tdl_pkg::*;

	logic              push_valid, push_ready;
	q_item_t           push_item;
	logic              pop_valid, pop_ready;
	q_item_t           pop_item;
	logic [CODE_W-1:0] consume_code_q;
	logic              reg_sel;

	// Register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_CONSUME_CODE);
	assign prdata  = reg_sel ? CFG_DATA_W'(consume_code_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consume_code_q <= CONSUME_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			consume_code_q <= pwdata[CODE_W-1:0];
		end
	end

	// Front: accept and classify
	tdl_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	// Decoupling queue
	tdl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	// Back: table lookups and results
	tdl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (pop_valid),
		.q_ready     (pop_ready),
		.q_item      (pop_item),
		.consume_code(consume_code_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/tdl_checker.sv =====
// Port-level checks of the lexer scanner, bound to the top level.
`default_nettype none

module tdl_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire tdl_pkg::out_item_t  out_data
);

	// A stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Only the first result of a retract pair is not the last one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.rescanned && !out_data.stuck)
		else $error("non-final result is not a retract");

	// A dropped character is never also rescanned
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.stuck && out_data.rescanned))
		else $error("result both stuck and rescanned");

	// Code zero never produces a token
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_code != '0)
		else $error("token with code zero");

	// After the first of a pair is taken, the next shown result is its final one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last ##1 out_valid |-> out_data.last)
		else $error("retract pair not closed");

endmodule

bind table_driven_lexer_dfa tdl_checker u_tdl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

`default_nettype wire
